// ----- hdl/caret_escape_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// Caret escape decoder assertion macros
// Assertion wrappers shared by the decoder RTL; define NO_ASSERTIONS to drop
// them. Each macro expects clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef CARET_ESCAPE_DECODER_CORE_MACROS_SVH
`define CARET_ESCAPE_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent holds in the same cycle as the antecedent.
`define CED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("caret escape decoder check failed");

// Consequent holds in the cycle after the antecedent.
`define CED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("caret escape decoder check failed");

`else

`define CED_ASSERT_SAME(label, ante, cons)
`define CED_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/ced_pkg.sv -----
// ----------------------------------------------------------------------------
// Caret escape decoder package
// Shared types, character constants and byte helper functions.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam logic [7:0] CARET       = 8'd94;
    localparam logic [7:0] SHIFT_DELTA = 8'd64;
    localparam logic [7:0] SHIFT_LIMIT = 8'd63;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [7:0] CHAR_A      = 8'd97;
    localparam logic [7:0] CHAR_F      = 8'd102;
    localparam logic [7:0] ALPHA_BIAS  = 8'd87;

    // Pending window forms: empty, "^", "^^", "^^h" with h a hex digit.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CARET = 2'd1,
        PEND_TWO   = 2'd2,
        PEND_HEX   = 2'd3
    } ced_pend_t;

    // Tokens released by one input beat.
    typedef struct packed {
        logic [7:0] tok0;
        logic [7:0] tok1;
        logic [1:0] cnt;
        logic       last;
    } ced_res_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) || ((c >= CHAR_A) && (c <= CHAR_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = (c <= CHAR_NINE) ? (c - CHAR_ZERO) : (c - ALPHA_BIAS);
        return v[3:0];
    endfunction

    function automatic logic [7:0] shift_dec(input logic [7:0] c);
        return (c > SHIFT_LIMIT) ? (c - SHIFT_DELTA) : (c + SHIFT_DELTA);
    endfunction

endpackage

// ----- hdl/ced_step.sv -----
// ----------------------------------------------------------------------------
// Caret escape decoder step logic
// Combines the pending window with one input byte and yields the next
// window form and up to two released tokens.
// ----------------------------------------------------------------------------
module ced_step (
    input  ced_pkg::ced_pend_t pend,
    input  logic [7:0]         pend_h,
    input  logic [7:0]         ch,
    input  logic               last,
    output ced_pkg::ced_pend_t pend_next,
    output logic [7:0]         pend_h_next,
    output ced_pkg::ced_res_t  res
);
    import ced_pkg::*;

    logic       ch_hex;
    logic [7:0] ch_shift;
    logic [7:0] h_shift;
    logic [7:0] pair_val;
    ced_pend_t  core_next;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;

    assign ch_hex   = is_hex(ch);
    assign ch_shift = shift_dec(ch);
    assign h_shift  = shift_dec(pend_h);
    assign pair_val = {hex_val(pend_h), hex_val(ch)};

    // Next window form
    always_comb
    begin
        core_next   = pend;
        pend_h_next = pend_h;
        unique case (pend)
            PEND_NONE:
            begin
                core_next = (ch == CARET) ? PEND_CARET : PEND_NONE;
            end
            PEND_CARET:
            begin
                core_next = (ch == CARET) ? PEND_TWO : PEND_NONE;
            end
            PEND_TWO:
            begin
                if (ch_hex)
                begin
                    core_next   = PEND_HEX;
                    pend_h_next = ch;
                end
                else
                begin
                    core_next = (ch_shift == CARET) ? PEND_CARET : PEND_NONE;
                end
            end
            PEND_HEX:
            begin
                if (ch_hex)
                begin
                    core_next = (pair_val == CARET) ? PEND_CARET : PEND_NONE;
                end
                else
                begin
                    core_next = (ch == CARET) ? PEND_CARET : PEND_NONE;
                end
            end
        endcase
        pend_next = last ? PEND_NONE : core_next;
    end

    // Released tokens
    always_comb
    begin
        n  = 2'd0;
        b0 = ch;
        b1 = ch;
        unique case (pend)
            PEND_NONE:
            begin
                if (ch != CARET)
                begin
                    b0 = ch;
                    n  = 2'd1;
                end
            end
            PEND_CARET:
            begin
                if (ch != CARET)
                begin
                    b0 = CARET;
                    b1 = ch;
                    n  = 2'd2;
                end
            end
            PEND_TWO:
            begin
                if (!ch_hex && (ch_shift != CARET))
                begin
                    b0 = ch_shift;
                    n  = 2'd1;
                end
            end
            PEND_HEX:
            begin
                if (ch_hex)
                begin
                    if (pair_val != CARET)
                    begin
                        b0 = pair_val;
                        n  = 2'd1;
                    end
                end
                else
                begin
                    b0 = h_shift;
                    b1 = ch;
                    n  = (ch != CARET) ? 2'd2 : 2'd1;
                end
            end
        endcase
        // Flush whatever stays pending at the end of the text.
        if (last)
        begin
            unique case (core_next)
                PEND_NONE:
                begin
                    n = n;
                end
                PEND_CARET:
                begin
                    if (n == 2'd0)
                        b0 = CARET;
                    else
                        b1 = CARET;
                    n = n + 2'd1;
                end
                PEND_TWO:
                begin
                    b0 = CARET;
                    b1 = CARET;
                    n  = 2'd2;
                end
                PEND_HEX:
                begin
                    b0 = shift_dec(ch);
                    n  = 2'd1;
                end
            endcase
        end
        res.tok0 = b0;
        res.tok1 = b1;
        res.cnt  = n;
        res.last = last;
    end

endmodule

// ----- hdl/ced_out_buf.sv -----
// ----------------------------------------------------------------------------
// Caret escape decoder output register
// Holds up to two tokens of one input beat and drains them one beat per
// cycle on the master side while m_axis_tready is high.
// ----------------------------------------------------------------------------
`include "caret_escape_decoder_core_macros.svh"

module ced_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              offer,
    input  ced_pkg::ced_res_t res,
    output logic              take,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] token_out
    output logic              m_axis_tlast    // token_last
);
    import ced_pkg::*;

    logic [7:0] head_reg;
    logic [7:0] head_next;
    logic [7:0] tail_reg;
    logic [7:0] tail_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       last_reg;
    logic       last_next;
    logic       pop;
    logic       room;
    logic       load;

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign room = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign take = offer && ((res.cnt == 2'd0) || room);
    assign load = take && (res.cnt != 2'd0);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (load)
        begin
            head_next = res.tok0;
            tail_next = res.tok1;
            cnt_next  = res.cnt;
            last_next = res.last;
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = head_reg;
    assign m_axis_tlast  = last_reg && (cnt_reg == 2'd1);

    `CED_ASSERT_SAME(a_no_load_when_full, cnt_reg == 2'd2, !load)
    `CED_ASSERT_NEXT(a_pair_drains, pop && (cnt_reg == 2'd2), (cnt_reg == 2'd1) && m_axis_tvalid)
    `CED_ASSERT_SAME(a_count_bounded, 1'b1, cnt_reg != 2'd3)

endmodule

// ----- hdl/caret_escape_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Caret escape decoder core
// Decodes "^^" escapes in a byte stream: "^^" plus two lowercase hex digits
// gives that byte, "^^" plus any other byte c gives c-64 or c+64; decoded
// bytes may start a new escape, and the last beat flushes the window.
// ----------------------------------------------------------------------------
// One input beat can be taken every cycle while the input register is free
// or its beat moves on. A beat is held in the input register, decoded
// against the pending window in one pass, and its tokens (none, one or two)
// are loaded into the output register once it has room. The output register
// drains one token per cycle while m_axis_tready is high; sustained rate is
// one beat per cycle for single-token beats, and a beat that releases two
// tokens holds off the next load until its last token drains. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "caret_escape_decoder_core_macros.svh"

module caret_escape_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] char_in
    input  logic       s_axis_tlast,    // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] token_out
    output logic       m_axis_tlast     // token_last
);
    import ced_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    ced_pend_t  pend_reg;
    ced_pend_t  pend_next;
    logic [7:0] pend_h_reg;
    logic [7:0] pend_h_next;
    ced_res_t   res;
    logic       take;
    logic       accept;

    assign s_axis_tready = !in_valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (take)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= PEND_NONE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (take)
                pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (take)
            pend_h_reg <= pend_h_next;
    end

    ced_step u_step (
        .pend        (pend_reg),
        .pend_h      (pend_h_reg),
        .ch          (in_char_reg),
        .last        (in_last_reg),
        .pend_next   (pend_next),
        .pend_h_next (pend_h_next),
        .res         (res)
    );

    ced_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .offer         (in_valid_reg),
        .res           (res),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `CED_ASSERT_NEXT(a_last_clears_window, take && in_last_reg, pend_reg == PEND_NONE)
    `CED_ASSERT_SAME(a_full_input_moves, accept && in_valid_reg, take)
    `CED_ASSERT_SAME(a_hex_held, pend_reg == PEND_HEX, is_hex(pend_h_reg))

endmodule
